### hdl/gdps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdps_pkg
// Shared types and constants of the gate delay pulse shaper.
// ----------------------------------------------------------------------------
package gdps_pkg;

    localparam int COUNT_WIDTH_DEF = 21;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DELAY_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_SAMPLES = 2'd1;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_COUNTING = 2'd1,
        MODE_HIGH     = 2'd2,
        MODE_PULSING  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0] action;
        logic       gate_b;
    } item_t;

    typedef struct packed {
        logic valid;
        logic shaped_gate;
    } result_t;

endpackage

### hdl/gdps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdps_core
// Shaper state (mode, countdown, note and edge tracking) and its per-item
// update; consumes one registered item per step strobe.
// ----------------------------------------------------------------------------
module gdps_core #(
    parameter int COUNT_WIDTH = gdps_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  gdps_pkg::item_t        item,
    input  logic [COUNT_WIDTH-1:0] delay_samples,
    input  logic [COUNT_WIDTH-1:0] pulse_samples,
    output gdps_pkg::result_t      result
);
    import gdps_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

    mode_t                  mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic                   note_held_reg, note_held_next;
    logic                   last_gate_b_reg, last_gate_b_next;

    mode_t                  fire_mode;
    logic [COUNT_WIDTH-1:0] fire_rem;
    mode_t                  tick_mode;
    logic [COUNT_WIDTH-1:0] tick_rem;

    // Mode and count that a trigger starts from
    always_comb begin
        if (delay_samples == CNT_ZERO) begin
            if (pulse_samples != CNT_ZERO) begin
                fire_mode = MODE_PULSING;
                fire_rem  = pulse_samples;
            end else begin
                fire_mode = MODE_HIGH;
                fire_rem  = CNT_ZERO;
            end
        end else begin
            fire_mode = MODE_COUNTING;
            fire_rem  = delay_samples;
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        remaining_next   = remaining_reg;
        note_held_next   = note_held_reg;
        last_gate_b_next = last_gate_b_reg;
        tick_mode        = mode_reg;
        tick_rem         = remaining_reg;
        result           = '0;

        case (action_t'(item.action))
            ACT_NOTE_ON: begin
                note_held_next = 1'b1;
                mode_next      = fire_mode;
                remaining_next = fire_rem;
            end
            ACT_NOTE_OFF: begin
                note_held_next = 1'b0;
                if (mode_reg == MODE_HIGH) begin
                    mode_next      = MODE_IDLE;
                    remaining_next = CNT_ZERO;
                end
            end
            ACT_TICK: begin
                // Rising edge of the second gate retriggers before the output
                if (item.gate_b && !last_gate_b_reg) begin
                    tick_mode = fire_mode;
                    tick_rem  = fire_rem;
                end
                last_gate_b_next = item.gate_b;
                result.valid     = 1'b1;
                mode_next        = tick_mode;
                remaining_next   = tick_rem;

                unique case (tick_mode)
                    MODE_COUNTING: begin
                        if (tick_rem <= CNT_ONE) begin
                            if (pulse_samples != CNT_ZERO) begin
                                mode_next      = MODE_PULSING;
                                remaining_next = pulse_samples;
                            end else begin
                                mode_next      = note_held_reg ? MODE_HIGH : MODE_IDLE;
                                remaining_next = CNT_ZERO;
                            end
                        end else begin
                            remaining_next = tick_rem - CNT_ONE;
                        end
                    end
                    MODE_HIGH: begin
                        result.shaped_gate = 1'b1;
                    end
                    MODE_PULSING: begin
                        result.shaped_gate = 1'b1;
                        if (tick_rem <= CNT_ONE) begin
                            mode_next      = MODE_IDLE;
                            remaining_next = CNT_ZERO;
                        end else begin
                            remaining_next = tick_rem - CNT_ONE;
                        end
                    end
                    default: begin
                        result.shaped_gate = 1'b0;
                    end
                endcase
            end
            default: begin
                // unused action code: drop
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            remaining_reg   <= CNT_ZERO;
            note_held_reg   <= 1'b0;
            last_gate_b_reg <= 1'b0;
        end else if (step) begin
            mode_reg        <= mode_next;
            remaining_reg   <= remaining_next;
            note_held_reg   <= note_held_next;
            last_gate_b_reg <= last_gate_b_next;
        end
    end

endmodule

### hdl/gate_delay_pulse_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_delay_pulse_shaper
// Delayed, retriggerable one-shot gate shaper, one item per sample event.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock: note-on, note-off or sample tick. Each
// tick returns one output transaction with the gate level through the input
// register, then the result register; note events return nothing. The
// throughput of one item per cycle is held as long as the result side takes
// its data; the combinational state update between the two registers sets it.
// Configuration writes on cfg_* are always ready and take effect at once;
// write them only while no transaction is in flight.
module gate_delay_pulse_shaper #(
    parameter int COUNT_WIDTH = gdps_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,  // [0] gate_b
    input  logic [1:0]                             s_axis_tuser,  // [1:0] action
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // [0] shaped_gate
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gdps_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [COUNT_WIDTH-1:0]                 cfg_data
);
    import gdps_pkg::*;

    logic [COUNT_WIDTH-1:0] delay_samples_reg;
    logic [COUNT_WIDTH-1:0] pulse_samples_reg;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    advance;
    result_t result;

    logic m_valid_reg;
    logic m_gate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_samples_reg <= '0;
            pulse_samples_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DELAY_SAMPLES: delay_samples_reg <= cfg_data;
                CFG_PULSE_SAMPLES: pulse_samples_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Registered item moves on when the result slot is free or draining
    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.action <= s_axis_tuser;
            in_item_reg.gate_b <= s_axis_tdata[0];
        end
    end

    gdps_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .item          (in_item_reg),
        .delay_samples (delay_samples_reg),
        .pulse_samples (pulse_samples_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance && result.valid) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            m_gate_reg <= result.shaped_gate;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_gate_reg};

endmodule
